### src/mtcc_pkg.sv
// Shared types, character codes and the CRC step for the meter telegram CRC checker.
// No dependencies; every other file of the block imports this package.
package mtcc_pkg;

	localparam logic [7:0]  CHAR_MARK = 8'h21;
	localparam logic [7:0]  CHAR_CR   = 8'h0D;
	localparam logic [7:0]  CHAR_LF   = 8'h0A;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'h0000;

	typedef enum logic [2:0] {
		ST_MATCH    = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_NO_MARK  = 3'd2,
		ST_MISSING  = 3'd3,
		ST_BAD_TEXT = 3'd4
	} check_status_t;

	// One classified telegram byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       is_mark;
		logic       is_crlf;
		logic       hex_ok;
		logic [3:0] hex_digit;
		logic       last;
	} item_t;

	// Reflected CRC-16 update over one whole byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### src/meter_telegram_crc_checker.sv
// Top level of the meter telegram CRC checker.
// Instantiates mtcc_front, mtcc_queue and mtcc_back; types come from mtcc_pkg.
//
// The checker takes one telegram byte per beat on the input channel and sustains one
// beat per clock cycle. Every byte up to and including the first '!' goes through a
// reflected CRC-16 (polynomial 0xA001, start value 0, no final XOR) that updates one
// whole byte in a single cycle. Bytes after the '!' other than CR and LF must be hex
// digits; they are shifted into a 16-bit register, so only the last four digits count.
// Any other character there, a second '!' included, flags the CRC text as bad. The
// beat with end_of_telegram set is processed like the others and then yields exactly
// one result beat (status, computed CRC, received CRC), after which all telegram state
// returns to its reset values. Other beats yield no result. Status codes: 0 match,
// 1 mismatch, 2 no '!', 3 missing CRC, 4 bad CRC text; received_crc reads 0 for the
// last three. A result passes through the QUEUE_DEPTH-beat queue and then the result
// register. The queue lets the input keep flowing while a finished result waits to be
// taken; only a last byte waits for the result register, so input stalls only once the
// queue has filled behind it.
module meter_telegram_crc_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_telegram,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  check_status,
	output logic [15:0] computed_crc,
	output logic [15:0] received_crc
);
	import mtcc_pkg::*;

	// Classified beats between the front end and the queue.
	logic  push;
	item_t push_item;
	logic  queue_full;

	// Beats leaving the queue toward the CRC and hex logic.
	logic  pop;
	logic  pop_valid;
	item_t pop_item;

	// The front end decodes each byte once: mark, line ending, hex digit and value.
	mtcc_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_telegram (end_of_telegram),
		.push            (push),
		.push_item       (push_item),
		.queue_full      (queue_full)
	);

	// The queue decouples input acceptance from the result handshake.
	mtcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	// The back end holds the running CRC, the hex register and the result register.
	mtcc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (pop_valid),
		.item         (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.check_status (check_status),
		.computed_crc (computed_crc),
		.received_crc (received_crc)
	);

endmodule

### src/mtcc_front.sv
// Front end of the meter telegram CRC checker: accepts bytes and classifies them.
// Depends on mtcc_pkg; feeds mtcc_queue.
module mtcc_front (
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic            end_of_telegram,
	output logic            push,
	output mtcc_pkg::item_t push_item,
	input  logic            queue_full
);
	import mtcc_pkg::*;

	logic is_num;
	logic is_upper;
	logic is_lower;

	always_comb begin
		is_num   = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h46);
		is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h66);

		push_item.data      = data_byte;
		push_item.is_mark   = (data_byte == CHAR_MARK);
		push_item.is_crlf   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
		push_item.hex_ok    = is_num || is_upper || is_lower;
		// Letters A-F and a-f share their low nibble 1..6; adding nine gives 10..15.
		push_item.hex_digit = is_num ? data_byte[3:0] : data_byte[3:0] + 4'd9;
		push_item.last      = end_of_telegram;
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

endmodule

### src/mtcc_queue.sv
// Short FIFO of classified beats between the front and the back of the checker.
// Depends on mtcc_pkg for the beat type.
module mtcc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mtcc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output mtcc_pkg::item_t pop_item
);
	import mtcc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");

endmodule

### src/mtcc_back.sv
// Back end of the checker: CRC register, hex accumulator, flags and result register.
// Depends on mtcc_pkg; consumes beats from mtcc_queue.
module mtcc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  mtcc_pkg::item_t item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      check_status,
	output logic [15:0]     computed_crc,
	output logic [15:0]     received_crc
);
	import mtcc_pkg::*;

	logic          after_mark_q;
	logic [15:0]   crc_q;
	logic [15:0]   acc_q;
	logic          digit_q;
	logic          bad_q;

	logic          out_valid_q;
	check_status_t status_q;
	logic [15:0]   crc_out_q;
	logic [15:0]   rx_out_q;

	logic          after_mark_d;
	logic [15:0]   crc_d;
	logic [15:0]   acc_d;
	logic          digit_d;
	logic          bad_d;
	check_status_t status_d;
	logic [15:0]   rx_d;
	logic          result_load;

	// Only a last beat needs room in the result register; others drain freely.
	assign pop         = item_valid && (!item.last || !out_valid_q || !out_stall);
	assign result_load = pop && item.last;

	always_comb begin
		after_mark_d = after_mark_q;
		crc_d        = crc_q;
		acc_d        = acc_q;
		digit_d      = digit_q;
		bad_d        = bad_q;
		if (!after_mark_q) begin
			crc_d = crc_byte(crc_q, item.data);
			if (item.is_mark) begin
				after_mark_d = 1'b1;
			end
		end else if (!item.is_crlf) begin
			if (item.hex_ok) begin
				acc_d   = {acc_q[11:0], item.hex_digit};
				digit_d = 1'b1;
			end else begin
				bad_d = 1'b1;
			end
		end

		rx_d = 16'h0000;
		if (!after_mark_d) begin
			status_d = ST_NO_MARK;
		end else if (!digit_d && !bad_d) begin
			status_d = ST_MISSING;
		end else if (bad_d) begin
			status_d = ST_BAD_TEXT;
		end else begin
			rx_d     = acc_d;
			status_d = (acc_d == crc_d) ? ST_MATCH : ST_MISMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_mark_q <= 1'b0;
			crc_q        <= CRC_INIT;
			acc_q        <= '0;
			digit_q      <= 1'b0;
			bad_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (result_load) begin
				after_mark_q <= 1'b0;
				crc_q        <= CRC_INIT;
				acc_q        <= '0;
				digit_q      <= 1'b0;
				bad_q        <= 1'b0;
			end else if (pop) begin
				after_mark_q <= after_mark_d;
				crc_q        <= crc_d;
				acc_q        <= acc_d;
				digit_q      <= digit_d;
				bad_q        <= bad_d;
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			status_q  <= status_d;
			crc_out_q <= crc_d;
			rx_out_q  <= rx_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign check_status = status_q;
	assign computed_crc = crc_out_q;
	assign received_crc = rx_out_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> (!after_mark_q && crc_q == CRC_INIT && acc_q == '0
			&& !digit_q && !bad_q))
		else $error("telegram state not cleared after last beat");

	a_pre_mark_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!after_mark_q |-> (acc_q == '0 && !digit_q && !bad_q))
		else $error("CRC text state changed before the mark");

	a_rx_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_NO_MARK || status_q == ST_MISSING
			|| status_q == ST_BAD_TEXT)) |-> (rx_out_q == 16'h0000))
		else $error("received CRC not zero on a failed parse");

	a_match_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_MATCH) |-> (rx_out_q == crc_out_q))
		else $error("match reported on unequal CRC values");

endmodule

### tb/tb.sv
// Self-checking testbench for meter_telegram_crc_checker.
// It predicts each telegram's CRC verdict itself and checks every result beat field by field.
// Depends on mtcc_pkg and the checker RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtcc_pkg::*;

	// A watchdog limit on cycles in which neither channel moves a beat. It must exceed the
	// longest quiet stretch of a correct run: the sender's idle gap after a beat or, for a
	// paused sender, a result's way through the queue and result register plus a receiver
	// stall, during which input can back up behind the stalled result.
	localparam int unsigned QUIET_LIMIT = 200;
	// Cycles to linger once nothing is outstanding, to catch stray result beats.
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned RANDOM_BYTES = 1500;
	localparam int unsigned DRAIN_EVERY = 300;

	// Shapes of generated telegrams.
	typedef enum int {
		TG_GOOD,
		TG_WRONG_CRC,
		TG_BAD_TEXT,
		TG_NO_MARK,
		TG_MISSING,
		TG_LOOSE
	} telegram_kind_t;

	// One byte waiting to go out on the input channel. The gap is the number of idle
	// cycles the sender holds after this beat. The drain flag makes the sender wait
	// before this byte until every outstanding verdict has come back.
	typedef struct {
		logic [7:0]  data;
		logic        last;
		int unsigned gap;
		bit          drain;
	} byte_beat_t;

	// The verdict that is expected for one telegram.
	typedef struct {
		check_status_t status;
		logic [15:0]   crc_calc;
		logic [15:0]   crc_rx;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_telegram = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  check_status;
	logic [15:0] computed_crc;
	logic [15:0] received_crc;

	byte_beat_t  bytes_to_send[$];
	verdict_t    verdicts_due[$];
	int unsigned mismatch_count = 0;

	// Telegram state of the predictor, which mirrors what the checker must hold.
	bit          seen_mark;
	logic [15:0] crc_run;
	logic [15:0] hex_shift;
	bit          got_digit;
	bit          text_broken;

	// Driver, receiver and monitor bookkeeping.
	byte_beat_t  head;
	logic        next_valid;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned results_taken;
	int unsigned quiet_cycles;
	verdict_t    oldest;

	// Stimulus generator knobs.
	bit          sender_calm = 1'b0;
	bit          drain_next = 1'b0;

	meter_telegram_crc_checker dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_telegram (end_of_telegram),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.check_status    (check_status),
		.computed_crc    (computed_crc),
		.received_crc    (received_crc)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Reflected CRC-16, fed one data bit at a time, LSB first. This gives the same result
	// as XOR-ing in the whole byte and then shifting eight times.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		int          i;
		r = crc;
		for (i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// Returns 1 and the nibble for 0-9, a-f and A-F, and 0 for anything else.
	function automatic bit hex_decode(input logic [7:0] b, output logic [3:0] v);
		v = 4'h0;
		if (b >= "0" && b <= "9") begin
			v = 4'(b - "0");
			return 1'b1;
		end
		if (b >= "A" && b <= "F") begin
			v = 4'(b - "A" + 8'd10);
			return 1'b1;
		end
		if (b >= "a" && b <= "f") begin
			v = 4'(b - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) begin
			return 8'("0" + n);
		end
		return 8'((upper ? "A" : "a") + n - 8'd10);
	endfunction

	function automatic void clear_telegram();
		seen_mark   = 1'b0;
		crc_run     = CRC_INIT;
		hex_shift   = 16'h0000;
		got_digit   = 1'b0;
		text_broken = 1'b0;
	endfunction

	// Predictor: folds one accepted byte into the telegram state. On the last byte it
	// queues the verdict and starts over. The status priority is: no mark, then
	// missing CRC, then bad CRC text, then the comparison.
	function automatic void absorb_byte(input logic [7:0] b, input logic last);
		logic [3:0] nib;
		verdict_t   v;
		if (!seen_mark) begin
			crc_run = crc_update(crc_run, b);
			if (b == CHAR_MARK) begin
				seen_mark = 1'b1;
			end
		end else if (b != CHAR_CR && b != CHAR_LF) begin
			if (hex_decode(b, nib)) begin
				hex_shift = {hex_shift[11:0], nib};
				got_digit = 1'b1;
			end else begin
				text_broken = 1'b1;
			end
		end
		if (last) begin
			v.crc_calc = crc_run;
			v.crc_rx   = 16'h0000;
			if (!seen_mark) begin
				v.status = ST_NO_MARK;
			end else if (!got_digit && !text_broken) begin
				v.status = ST_MISSING;
			end else if (text_broken) begin
				v.status = ST_BAD_TEXT;
			end else begin
				v.crc_rx = hex_shift;
				v.status = (hex_shift == crc_run) ? ST_MATCH : ST_MISMATCH;
			end
			verdicts_due = {verdicts_due, v};
			clear_telegram();
		end
	endfunction

	// Queues a telegram byte by byte and marks its final byte as the last one. Every
	// byte draws its own trailing gap unless the sender is in a calm stretch.
	task automatic send_telegram(input logic [7:0] tg[$]);
		byte_beat_t beat;
		if ($urandom_range(0, 9) == 0) begin
			sender_calm = !sender_calm;
		end
		foreach (tg[k]) begin
			beat.data  = tg[k];
			beat.last  = (k == tg.size() - 1);
			beat.gap   = sender_calm ? 0 : $urandom_range(0, 4);
			beat.drain = drain_next;
			drain_next = 1'b0;
			bytes_to_send = {bytes_to_send, beat};
		end
	endtask

	// Most random telegrams are well formed: a random header, the mark, four hex digits
	// (sometimes with extra leading digits that wrap out) and an optional CR LF. The
	// rest have a wrong CRC, broken CRC text, no mark or no digits at all, or are loose
	// bytes with frequent marks.
	task automatic queue_random_telegram();
		logic [7:0]     tg[$];
		logic [15:0]    crc;
		logic [15:0]    sent_crc;
		logic [7:0]     b;
		logic [3:0]     nib;
		int unsigned    pick;
		int unsigned    mark_pos;
		int             i;
		telegram_kind_t kind;
		pick = $urandom_range(0, 99);
		kind = (pick < 55) ? TG_GOOD :
			(pick < 65) ? TG_WRONG_CRC :
			(pick < 77) ? TG_BAD_TEXT :
			(pick < 84) ? TG_NO_MARK :
			(pick < 90) ? TG_MISSING : TG_LOOSE;
		crc = CRC_INIT;
		if (kind == TG_LOOSE) begin
			repeat ($urandom_range(1, 10)) begin
				b = ($urandom_range(0, 5) == 0) ? CHAR_MARK : 8'($urandom_range(0, 255));
				tg = {tg, b};
			end
		end else begin
			repeat ($urandom_range(0, 12)) begin
				b = 8'($urandom_range(0, 255));
				if (b == CHAR_MARK) begin
					b = 8'h2F;
				end
				crc = crc_update(crc, b);
				tg = {tg, b};
			end
			if (kind == TG_NO_MARK) begin
				if (tg.size() == 0) begin
					tg = {tg, 8'h41};
				end
			end else begin
				mark_pos = tg.size();
				tg = {tg, CHAR_MARK};
				crc = crc_update(crc, CHAR_MARK);
				if ($urandom_range(0, 3) == 0) begin
					tg = {tg, CHAR_CR};
					tg = {tg, CHAR_LF};
				end
				if (kind != TG_MISSING) begin
					sent_crc = crc;
					if (kind == TG_WRONG_CRC) begin
						sent_crc = crc ^ 16'($urandom_range(1, 65535));
					end
					if ($urandom_range(0, 3) == 0) begin
						repeat ($urandom_range(1, 3)) begin
							tg = {tg, hex_char(4'($urandom_range(0, 15)),
								$urandom_range(0, 1))};
						end
					end
					for (i = 3; i >= 0; i--) begin
						tg = {tg, hex_char(sent_crc[4*i +: 4], $urandom_range(0, 1))};
					end
					if (kind == TG_BAD_TEXT) begin
						// Any byte that is neither a hex digit nor CR or LF; a second
						// mark is one of them.
						do begin
							b = 8'($urandom_range(0, 255));
						end while (hex_decode(b, nib) || b == CHAR_CR || b == CHAR_LF);
						tg.insert($urandom_range(mark_pos + 1, tg.size()), b);
					end
				end
				if ($urandom_range(0, 1) == 1) begin
					tg = {tg, CHAR_CR};
					tg = {tg, CHAR_LF};
				end
			end
		end
		send_telegram(tg);
	endtask

	// Sender. A new beat goes out only when the channel is free, that is, when nothing
	// is driven or the current beat is taken at this edge. A stalled beat keeps its
	// payload. A byte flagged for draining waits until the last beat is gone and every
	// outstanding verdict has come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			data_byte       <= 8'h00;
			end_of_telegram <= 1'b0;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (bytes_to_send.size() > 0 && (!bytes_to_send[0].drain ||
					(!in_valid && verdicts_due.size() == 0))) begin
				head = bytes_to_send.pop_front();
				data_byte       <= head.data;
				end_of_telegram <= head.last;
				gap_left = head.gap;
				next_valid = 1'b1;
			end
			in_valid <= next_valid;
		end
	end

	// Receiver. After each result beat it draws how many cycles it will stall the next
	// one. The count only runs down while a result is on offer, so the stall really
	// holds that result back and lets input pile up behind it. Now and then a run of
	// results is taken without any stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			results_taken = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_taken++;
				stall_left = (results_taken % 40 < 10) ? 0 : $urandom_range(0, 4);
			end else if (out_valid && stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	// Monitor. Input beats are folded into the predictor before output beats are
	// checked, so the outcome does not depend on the order in which processes run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_telegram();
		end else begin
			if (in_valid && !in_stall) begin
				absorb_byte(data_byte, end_of_telegram);
			end
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("result beat with no telegram outstanding: status %0d",
						check_status);
					mismatch_count++;
				end else begin
					oldest = verdicts_due.pop_front();
					if (check_status !== oldest.status) begin
						$error("check_status: expected %0d, got %0d",
							oldest.status, check_status);
						mismatch_count++;
					end
					if (computed_crc !== oldest.crc_calc) begin
						$error("computed_crc: expected %04h, got %04h",
							oldest.crc_calc, computed_crc);
						mismatch_count++;
					end
					if (received_crc !== oldest.crc_rx) begin
						$error("received_crc: expected %04h, got %04h",
							oldest.crc_rx, received_crc);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[meter_telegram_crc_checker] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]  tg[$];
		logic [15:0] c;
		int unsigned next_drain_at;

		// Directed telegrams. They cover a bare mark, a single byte of each extreme value
		// without a mark, a mark followed only by CR LF, a non-hex character, a second
		// mark, and an exact match in mixed case. They also cover a match whose extra
		// leading digit wraps out of the register, and a mismatch that uses the digit
		// extremes.
		c = crc_update(CRC_INIT, CHAR_MARK);
		tg = '{CHAR_MARK};
		send_telegram(tg);
		tg = '{8'h00};
		send_telegram(tg);
		tg = '{8'hFF};
		send_telegram(tg);
		tg = '{CHAR_MARK, CHAR_CR, CHAR_LF};
		send_telegram(tg);
		tg = '{CHAR_MARK, "g"};
		send_telegram(tg);
		tg = '{CHAR_MARK, CHAR_MARK};
		send_telegram(tg);
		tg = '{CHAR_MARK, hex_char(c[15:12], 1'b1), hex_char(c[11:8], 1'b0),
			hex_char(c[7:4], 1'b1), hex_char(c[3:0], 1'b0)};
		send_telegram(tg);
		tg = '{CHAR_MARK, "F", hex_char(c[15:12], 1'b0), hex_char(c[11:8], 1'b1),
			hex_char(c[7:4], 1'b0), hex_char(c[3:0], 1'b1)};
		send_telegram(tg);
		tg = '{CHAR_MARK, "9", "a", "F", "0"};
		send_telegram(tg);

		// Random telegrams. The sender drains the checker at the start of this phase and
		// again every few hundred bytes.
		drain_next = 1'b1;
		next_drain_at = bytes_to_send.size() + DRAIN_EVERY;
		while (bytes_to_send.size() < RANDOM_BYTES + 28) begin
			if (bytes_to_send.size() >= next_drain_at) begin
				drain_next = 1'b1;
				next_drain_at += DRAIN_EVERY;
			end
			queue_random_telegram();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() > 0 || in_valid || verdicts_due.size() > 0) begin
			@(posedge clk);
		end
		// A result appears once its last byte has passed the queue and the result register.
		// Lingering for TAIL_CYCLES after that catches any result beat that should not be there.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[meter_telegram_crc_checker] OK");
		end else begin
			$display("[meter_telegram_crc_checker] ERROR");
		end
		$finish;
	end

endmodule
